FILE: hdl/e2c_pkg.sv
package e2c_pkg;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [11:0] SECS_PER_MIN  = 12'd60;
    localparam logic [15:0] DAYS_PER_WEEK = 16'd7;

    // reciprocals rounded up, exact over each dividend range
    // seconds >> 7 over 675, product >> 35
    localparam logic [25:0] RECIP_DAY  = 26'd50903317;
    // time of day >> 4 over 225, product >> 21
    localparam logic [13:0] RECIP_HOUR = 14'd9321;
    // seconds in the hour >> 2 over 15, product >> 14
    localparam logic [10:0] RECIP_MIN  = 11'd1093;
    // day number plus offset over 7, product >> 19
    localparam logic [16:0] RECIP_WEEK = 17'd74899;

    // 1970-01-01 was a Thursday
    localparam logic [15:0] WEEKDAY_OFS    = 16'd4;
    localparam logic [7:0]  YEARS_AT_START = 8'd70;
    // 2100 is the only year in range divisible by four that is not leap
    localparam logic [7:0]  CENTURY_NOLEAP = 8'd200;
    localparam logic [3:0]  LAST_MONTH    = 4'd11;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_YEAR,
        ST_MONTH,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_DAY,
        OP_TOD,
        OP_HOUR,
        OP_MREM,
        OP_MIN,
        OP_SEC
    } div_op_t;

    typedef struct packed {
        logic    start;
        logic    step;
        div_op_t op;
        logic    year_step;
        logic    year_end;
        logic    month_step;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic year_done;
        logic month_done;
    } status_t;

    function automatic div_op_t next_op(input div_op_t op);
        div_op_t n;
        case (op)
            OP_DAY:  n = OP_TOD;
            OP_TOD:  n = OP_HOUR;
            OP_HOUR: n = OP_MREM;
            OP_MREM: n = OP_MIN;
            OP_MIN:  n = OP_SEC;
            default: n = OP_SEC;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
        logic [4:0] n;
        case (mon)
            4'd1:                      n = leap ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

FILE: hdl/e2c_ctrl.sv
module e2c_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  e2c_pkg::status_t status,
    output e2c_pkg::cmd_t    cmd
);
    import e2c_pkg::*;

    state_t     state_reg, state_next;
    div_op_t    op_reg, op_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_DAY;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.op       = op_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_DIV;
                    op_next    = OP_DAY;
                end
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (op_reg == OP_SEC) begin
                    state_next = ST_YEAR;
                end else begin
                    op_next = next_op(op_reg);
                end
            end
            ST_YEAR: begin
                if (status.year_done) begin
                    cmd.year_end = 1'b1;
                    state_next   = ST_MONTH;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH: begin
                if (status.month_done) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_DIV && op_reg == OP_DAY)
        else $error("conversion did not start on the day division");

    a_div: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DIV && op_reg == OP_SEC |=> state_reg == ST_YEAR)
        else $error("division steps did not hand over to the year search");

    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH && (!m_valid_reg || m_ready) |=> m_valid_reg && s_ready)
        else $error("finished result not presented");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_ready && state_reg != ST_FINISH |=> !m_valid_reg)
        else $error("result beat repeated");

endmodule

FILE: hdl/e2c_datapath.sv
module e2c_datapath (
    input  logic             aclk,
    input  logic [31:0]      s_epoch_seconds,
    input  e2c_pkg::cmd_t    cmd,
    output e2c_pkg::status_t status,
    output logic [5:0]       m_second,
    output logic [5:0]       m_minute,
    output logic [4:0]       m_hour,
    output logic [2:0]       m_weekday,
    output logic [7:0]       m_years_since_1900,
    output logic [8:0]       m_day_of_year,
    output logic [3:0]       m_month,
    output logic [4:0]       m_day_of_month
);
    import e2c_pkg::*;

    logic [31:0] secs_reg, secs_next;
    logic [15:0] days_reg, days_next;
    logic [16:0] tod_reg, tod_next;
    logic [11:0] rem_reg, rem_next;
    logic [12:0] wq_reg, wq_next;
    logic [7:0]  year_reg, year_next;
    logic [8:0]  yday_reg, yday_next;
    logic [3:0]  mon_reg, mon_next;
    logic [5:0]  sec_reg, sec_next, min_reg, min_next;
    logic [4:0]  hour_reg, hour_next;
    logic [2:0]  wday_reg, wday_next;

    logic [50:0] day_prod;
    logic [32:0] tod_full;
    logic [25:0] hour_prod;
    logic [16:0] min_rem;
    logic [19:0] min_prod;
    logic [11:0] sec_full;
    logic [15:0] wk_num;
    logic [31:0] wk_prod;
    logic [15:0] wk_rem;

    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    logic [5:0]  o_sec_reg, o_min_reg;
    logic [4:0]  o_hour_reg, o_dom_reg;
    logic [2:0]  o_wday_reg;
    logic [7:0]  o_year_reg;
    logic [8:0]  o_yday_reg;
    logic [3:0]  o_mon_reg;

    // division by constants through rounded-up reciprocals
    assign day_prod  = {26'd0, secs_reg[31:7]} * {25'd0, RECIP_DAY};
    assign tod_full  = {1'b0, secs_reg} - ({17'd0, days_reg} * {16'd0, SECS_PER_DAY});
    assign hour_prod = {13'd0, tod_reg[16:4]} * {12'd0, RECIP_HOUR};
    assign min_rem   = tod_reg - ({12'd0, hour_reg} * SECS_PER_HOUR);
    assign min_prod  = {10'd0, rem_reg[11:2]} * {9'd0, RECIP_MIN};
    assign sec_full  = rem_reg - ({6'd0, min_reg} * SECS_PER_MIN);
    assign wk_num    = days_reg + WEEKDAY_OFS;
    assign wk_prod   = {16'd0, wk_num} * {15'd0, RECIP_WEEK};
    assign wk_rem    = wk_num - ({3'd0, wq_reg} * DAYS_PER_WEEK);

    assign leap = (year_reg[1:0] == 2'b00) && (year_reg != CENTURY_NOLEAP);
    assign ylen = leap ? 9'd366 : 9'd365;
    assign mlen = month_len(leap, mon_reg);

    always_comb begin
        status.year_done  = (days_reg < {7'd0, ylen});
        status.month_done = (mon_reg == LAST_MONTH) || (days_reg < {11'd0, mlen});
    end

    always_comb begin
        secs_next = secs_reg;
        days_next = days_reg;
        tod_next  = tod_reg;
        rem_next  = rem_reg;
        wq_next   = wq_reg;
        year_next = year_reg;
        yday_next = yday_reg;
        mon_next  = mon_reg;
        sec_next  = sec_reg;
        min_next  = min_reg;
        hour_next = hour_reg;
        wday_next = wday_reg;

        if (cmd.start) begin
            secs_next = s_epoch_seconds;
            year_next = YEARS_AT_START;
        end
        if (cmd.step) begin
            case (cmd.op)
                OP_DAY:  days_next = day_prod[50:35];
                OP_TOD:  tod_next  = tod_full[16:0];
                OP_HOUR: begin
                    hour_next = hour_prod[25:21];
                    wq_next   = wk_prod[31:19];
                end
                OP_MREM: begin
                    rem_next  = min_rem[11:0];
                    wday_next = wk_rem[2:0];
                end
                OP_MIN:  min_next = min_prod[19:14];
                OP_SEC:  sec_next = sec_full[5:0];
                default: ;
            endcase
        end
        if (cmd.year_step) begin
            days_next = days_reg - {7'd0, ylen};
            year_next = year_reg + 8'd1;
        end
        if (cmd.year_end) begin
            yday_next = days_reg[8:0];
            mon_next  = '0;
        end
        if (cmd.month_step) begin
            days_next = days_reg - {11'd0, mlen};
            mon_next  = mon_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        secs_reg <= secs_next;
        days_reg <= days_next;
        tod_reg  <= tod_next;
        rem_reg  <= rem_next;
        wq_reg   <= wq_next;
        year_reg <= year_next;
        yday_reg <= yday_next;
        mon_reg  <= mon_next;
        sec_reg  <= sec_next;
        min_reg  <= min_next;
        hour_reg <= hour_next;
        wday_reg <= wday_next;
        if (cmd.out_load) begin
            o_sec_reg  <= sec_reg;
            o_min_reg  <= min_reg;
            o_hour_reg <= hour_reg;
            o_wday_reg <= wday_reg;
            o_year_reg <= year_reg;
            o_yday_reg <= yday_reg;
            o_mon_reg  <= mon_reg;
            o_dom_reg  <= days_reg[4:0] + 5'd1;
        end
    end

    assign m_second           = o_sec_reg;
    assign m_minute           = o_min_reg;
    assign m_hour             = o_hour_reg;
    assign m_weekday          = o_wday_reg;
    assign m_years_since_1900 = o_year_reg;
    assign m_day_of_year      = o_yday_reg;
    assign m_month            = o_mon_reg;
    assign m_day_of_month     = o_dom_reg;

endmodule

FILE: hdl/epoch_seconds_to_calendar.sv
// channel  ports                          beat
// input    s_valid s_ready                s_epoch_seconds
// output   m_valid m_ready                m_second m_minute m_hour m_weekday
//                                         m_years_since_1900 m_day_of_year
//                                         m_month m_day_of_month
//
// One item at a time: the input is accepted while idle, then 6 division
// steps (reciprocal multiplies and remainder subtractions) give the time of
// day and weekday, a year search steps past whole years, a month search steps
// past whole months, and the output is loaded once the previous result is taken.
// Reset is synchronous, active low, and clears only the controller.
// s_ready is high only while idle; a waiting result does not block the next
// beat, which stalls only at the end if the previous result is still held.
module epoch_seconds_to_calendar (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_epoch_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_second,
    output logic [5:0]  m_minute,
    output logic [4:0]  m_hour,
    output logic [2:0]  m_weekday,
    output logic [7:0]  m_years_since_1900,
    output logic [8:0]  m_day_of_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day_of_month
);
    import e2c_pkg::*;

    cmd_t    cmd;
    status_t status;

    e2c_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    e2c_datapath u_datapath (
        .aclk               (aclk),
        .s_epoch_seconds    (s_epoch_seconds),
        .cmd                (cmd),
        .status             (status),
        .m_second           (m_second),
        .m_minute           (m_minute),
        .m_hour             (m_hour),
        .m_weekday          (m_weekday),
        .m_years_since_1900 (m_years_since_1900),
        .m_day_of_year      (m_day_of_year),
        .m_month            (m_month),
        .m_day_of_month     (m_day_of_month)
    );

endmodule

FILE: tb/tb.sv
module tb;

    localparam int unsigned FIRST_YEAR   = 1970;
    localparam int unsigned BASE_YEAR    = 1900;
    localparam int unsigned DAY_SECS     = 86400;
    localparam int unsigned HOUR_SECS    = 3600;
    localparam int unsigned MIN_SECS     = 60;
    localparam int unsigned THURSDAY     = 4;
    localparam int unsigned FEBRUARY     = 1;
    localparam int unsigned DECEMBER     = 11;
    localparam int unsigned HOLD_CYCLES  = 2000;
    localparam int unsigned CYCLE_LIMIT  = 1500000;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
        logic [3:0] month;
        logic [4:0] day_of_month;
    } calendar_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_epoch_seconds;
    logic        m_valid;
    logic        m_ready;
    logic [5:0]  m_second;
    logic [5:0]  m_minute;
    logic [4:0]  m_hour;
    logic [2:0]  m_weekday;
    logic [7:0]  m_years_since_1900;
    logic [8:0]  m_day_of_year;
    logic [3:0]  m_month;
    logic [4:0]  m_day_of_month;

    logic [31:0] pending_secs [$];
    calendar_t   expected_dates [$];

    logic        idle_on;
    logic        hold_req;
    int unsigned send_gap;
    int unsigned recv_gap;
    int unsigned hold_left;
    int unsigned cycles;
    int unsigned stamps_sent;
    int unsigned dates_checked;
    int unsigned errors;

    epoch_seconds_to_calendar u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_epoch_seconds    (s_epoch_seconds),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_second           (m_second),
        .m_minute           (m_minute),
        .m_hour             (m_hour),
        .m_weekday          (m_weekday),
        .m_years_since_1900 (m_years_since_1900),
        .m_day_of_year      (m_day_of_year),
        .m_month            (m_month),
        .m_day_of_month     (m_day_of_month)
    );

    function automatic bit is_leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned mon, input bit leap);
        int unsigned n;
        case (mon)
            FEBRUARY:    n = leap ? 29 : 28;
            3, 5, 8, 10: n = 30;
            default:     n = 31;
        endcase
        return n;
    endfunction

    function automatic calendar_t calendar_of(input logic [31:0] secs);
        int unsigned s;
        int unsigned tod;
        int unsigned days;
        int unsigned year;
        int unsigned ylen;
        int unsigned mon;
        int unsigned mlen;
        calendar_t   c;
        s    = secs;
        tod  = s % DAY_SECS;
        days = s / DAY_SECS;
        c.second  = 6'(tod % MIN_SECS);
        c.minute  = 6'((tod % HOUR_SECS) / MIN_SECS);
        c.hour    = 5'(tod / HOUR_SECS);
        c.weekday = 3'((days + THURSDAY) % 7);
        year = FIRST_YEAR;
        ylen = is_leap_year(year) ? 366 : 365;
        while (days >= ylen) begin
            days -= ylen;
            year++;
            ylen = is_leap_year(year) ? 366 : 365;
        end
        c.years_since_1900 = 8'(year - BASE_YEAR);
        c.day_of_year      = 9'(days);
        mon  = 0;
        mlen = month_length(mon, is_leap_year(year));
        while (mon < DECEMBER && days >= mlen) begin
            days -= mlen;
            mon++;
            mlen = month_length(mon, is_leap_year(year));
        end
        c.month        = 4'(mon);
        c.day_of_month = 5'(days + 1);
        return c;
    endfunction

    // mostly uniform, with a share near midnights, year ends, leap days, the epoch start and the top
    function automatic logic [31:0] random_epoch();
        int unsigned d;
        int unsigned y;
        int unsigned k;
        int unsigned r;
        case ($urandom_range(0, 9))
            6: begin
                d = $urandom_range(0, 49709);
                r = d * DAY_SECS + ($urandom_range(0, 1) ? $urandom_range(0, 59)
                                                         : DAY_SECS - 1 - $urandom_range(0, 59));
            end
            7: begin
                y = $urandom_range(FIRST_YEAR + 1, 2105);
                d = 0;
                for (k = FIRST_YEAR; k < y; k++)
                    d += is_leap_year(k) ? 366 : 365;
                case ($urandom_range(0, 2))
                    0: d += 0;
                    1: d += 59;
                    default: d += 60;
                endcase
                r = d * DAY_SECS - $urandom_range(0, 1);
            end
            8: r = $urandom_range(0, 32'h000F_FFFF);
            9: r = 32'hFFFF_FFFF - $urandom_range(0, 32'h00FF_FFFF);
            default: r = $urandom();
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid         <= 1'b0;
            s_epoch_seconds <= '0;
            send_gap        <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_dates.push_back(calendar_of(s_epoch_seconds));
                stamps_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_secs.size() != 0) begin
                    s_valid         <= 1'b1;
                    s_epoch_seconds <= pending_secs.pop_front();
                    send_gap        <= (idle_on && $urandom_range(0, 3) == 0) ?
                                       $urandom_range(1, 11) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        calendar_t want;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_gap  <= 0;
            hold_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_dates.size() == 0) begin
                    $error("result beat with no timestamp outstanding");
                    errors++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("second", want.second, m_second);
                    check_field("minute", want.minute, m_minute);
                    check_field("hour", want.hour, m_hour);
                    check_field("weekday", want.weekday, m_weekday);
                    check_field("years_since_1900", want.years_since_1900, m_years_since_1900);
                    check_field("day_of_year", want.day_of_year, m_day_of_year);
                    check_field("month", want.month, m_month);
                    check_field("day_of_month", want.day_of_month, m_day_of_month);
                    dates_checked++;
                end
            end
            if (hold_req) begin
                hold_left <= HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else if (idle_on && $urandom_range(0, 15) == 0) begin
                recv_gap <= $urandom_range(0, 10);
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int i;
        aresetn         = 1'b0;
        idle_on         = 1'b1;
        hold_req        = 1'b0;
        cycles          = 0;
        stamps_sent     = 0;
        dates_checked   = 0;
        errors          = 0;
        s_valid         = 1'b0;
        s_epoch_seconds = '0;
        m_ready         = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // epoch, unit rollovers, the 32-bit edges, leap days and century years
        pending_secs.push_back(32'd0);
        pending_secs.push_back(32'd1);
        pending_secs.push_back(32'd59);
        pending_secs.push_back(32'd60);
        pending_secs.push_back(32'd3599);
        pending_secs.push_back(32'd3600);
        pending_secs.push_back(32'd86399);
        pending_secs.push_back(32'd86400);
        pending_secs.push_back(32'd68169600);
        pending_secs.push_back(32'd94608000);
        pending_secs.push_back(32'd946684799);
        pending_secs.push_back(32'd946684800);
        pending_secs.push_back(32'd951782400);
        pending_secs.push_back(32'd951868800);
        pending_secs.push_back(32'd978220800);
        pending_secs.push_back(32'h7FFF_FFFF);
        pending_secs.push_back(32'h8000_0000);
        pending_secs.push_back(32'hAAAA_AAAA);
        pending_secs.push_back(32'h5555_5555);
        pending_secs.push_back(32'd4102358400);
        pending_secs.push_back(32'd4107542399);
        pending_secs.push_back(32'd4107542400);
        pending_secs.push_back(32'hFFFF_FFFE);
        pending_secs.push_back(32'hFFFF_FFFF);

        // wait until every date is out
        while (pending_secs.size() != 0 || s_valid || expected_dates.size() != 0)
            @(negedge aclk);

        // output held off while the sender keeps offering beats
        hold_req = 1'b1;
        @(negedge aclk);
        hold_req = 1'b0;
        for (i = 0; i < 20; i++)
            pending_secs.push_back(random_epoch());

        for (i = 0; i < 800; i++)
            pending_secs.push_back(random_epoch());
        while (pending_secs.size() != 0)
            @(negedge aclk);

        idle_on = 1'b0;
        for (i = 0; i < 160; i++)
            pending_secs.push_back(random_epoch());

        while (pending_secs.size() != 0 || s_valid || expected_dates.size() != 0)
            @(negedge aclk);
        repeat (300) @(negedge aclk);

        $display("Converted %0d timestamps, %0d dates checked: epoch to 2106, leap days,",
                 stamps_sent, dates_checked);
        $display("century years, the 32-bit limit, idling, a long output stall and a drain.");
        if (errors == 0 && expected_dates.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
